// ----- sv/heap_sort_engine_assert.svh -----
// ---------------------------------------------------------------------------
// heap_sort_engine_assert.svh
// Assertion macros used by the heap sort engine checker.
// ---------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hse_pkg.sv -----
// ---------------------------------------------------------------------------
// hse_pkg
// Shared constants and types of the heap sort engine.
// ---------------------------------------------------------------------------
package hse_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int FIELD_W       = 32;   // width of the key fields on the ports

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ROOT,
        ST_SWAP_RD,
        ST_SWAP,
        ST_SIFT,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

// ----- sv/hse_if.sv -----
// ---------------------------------------------------------------------------
// hse_if
// Valid/ready channels of the heap sort engine: keys in, sorted keys out.
// ---------------------------------------------------------------------------
interface hse_key_if;
    logic                         valid;
    logic                         ready;
    logic [hse_pkg::FIELD_W-1:0]  key;
    logic                         last_in;

    modport source (output valid, output key, output last_in, input ready);
    modport sink   (input valid, input key, input last_in, output ready);
endinterface

interface hse_sorted_if;
    logic                         valid;
    logic                         ready;
    logic [hse_pkg::FIELD_W-1:0]  sorted_key;
    logic                         last_out;
    logic                         dropped;

    modport source (output valid, output sorted_key, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_key, input last_out, input dropped,
                    output ready);
endinterface

// ----- sv/hse_ram.sv -----
// ---------------------------------------------------------------------------
// hse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module hse_ram #(
    parameter int WIDTH = hse_pkg::KEY_WIDTH_DEF,
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/heap_sort_engine.sv -----
// Keys are taken while collecting; after the last key the heap is built and then
// drained, and the sorted words are read out in order, each one held while the output
// stalls. The sift-down walk moves one tree level per cycle.
// Throughput: one set at a time.
// Reset: control state, count, overflow flag and mode clear; the key store is not
// cleared, every entry whose data is used is written before it is read.
// ---------------------------------------------------------------------------
// heap_sort_engine
// Collects keys into a RAM, heap sorts them in place and streams them out ascending.
// ---------------------------------------------------------------------------
module heap_sort_engine #(
    parameter int DEPTH     = hse_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = hse_pkg::KEY_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    hse_key_if.sink       keys,
    hse_sorted_if.source  sorted,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int KW = KEY_WIDTH;

    hse_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          mode_reg, mode_next;
    logic [CW-1:0] size_reg, size_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] par_reg, par_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          extract_reg, extract_next;
    logic [KW-1:0] hold_reg, hold_next;

    logic                   out_valid_reg, out_valid_next;
    logic [hse_pkg::FIELD_W-1:0] out_key_reg, out_key_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_drop_reg, out_drop_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a, ram_raddr_b;
    logic [KW-1:0] rda, rdb;

    logic          in_accept;
    logic          room;
    logic [CW-1:0] n_next;
    logic [CW-1:0] n_half;
    logic [CW-1:0] count_m1;
    logic [63:0]   key_wide;
    logic [KW-1:0] key_k;
    logic [63:0]   rd_wide;

    logic [XW-1:0] size_x;
    logic [XW-1:0] lc_cur, rc_cur;
    logic          left_ok;
    logic          right_big;
    logic [AW-1:0] big_idx;
    logic [KW-1:0] big_val;
    logic          swap_up;
    logic [XW-1:0] lc_big, rc_big;
    logic          deeper;
    logic          op_done;
    logic          emit_go;
    logic          emit_last;
    hse_pkg::state_t after_op;

    // true when a ranks above b; signed mode flips the sign bits
    function automatic logic ranks_above(input logic [KW-1:0] a, input logic [KW-1:0] b,
                                         input logic sgn);
        logic [KW-1:0] flip;
        flip         = '0;
        flip[KW-1]   = sgn;
        return (a ^ flip) > (b ^ flip);
    endfunction

    hse_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rda),
        .rdata_b (rdb)
    );

    assign in_accept = keys.valid && keys.ready;
    assign keys.ready = (state_reg == hse_pkg::ST_COLLECT);

    assign sorted.valid      = out_valid_reg;
    assign sorted.sorted_key = out_key_reg;
    assign sorted.last_out   = out_last_reg;
    assign sorted.dropped    = out_drop_reg;

    assign key_wide = 64'(keys.key);
    assign key_k    = key_wide[KW-1:0];
    assign rd_wide  = 64'(rda);

    assign room     = count_reg < CW'(DEPTH);
    assign n_next   = room ? count_reg + CW'(1) : count_reg;
    assign n_half   = (n_next >> 1) - CW'(1);
    assign count_m1 = count_reg - CW'(1);

    // child addresses of the node being sifted; rda/rdb hold left/right in ST_SIFT
    assign size_x  = XW'(size_reg);
    assign lc_cur  = XW'({cur_reg, 1'b1});
    assign rc_cur  = lc_cur + XW'(1);
    assign left_ok = lc_cur < size_x;

    assign right_big = (rc_cur < size_x) && ranks_above(rdb, rda, mode_reg);
    assign big_idx   = right_big ? rc_cur[AW-1:0] : lc_cur[AW-1:0];
    assign big_val   = right_big ? rdb : rda;
    assign swap_up   = ranks_above(big_val, hold_reg, mode_reg);
    assign lc_big    = XW'({big_idx, 1'b1});
    assign rc_big    = lc_big + XW'(1);
    assign deeper    = lc_big < size_x;

    assign op_done   = ((state_reg == hse_pkg::ST_SIFT) && !swap_up) ||
                       (state_reg == hse_pkg::ST_FINISH);
    assign emit_go   = !out_valid_reg || sorted.ready;
    assign emit_last = CW'(idx_reg) == count_m1;

    always_comb
    begin
        if (!extract_reg)
        begin
            after_op = (par_reg != '0) ? hse_pkg::ST_LOAD : hse_pkg::ST_SWAP_RD;
        end
        else
        begin
            after_op = (end_reg == AW'(1)) ? hse_pkg::ST_EMIT_RD : hse_pkg::ST_SWAP_RD;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hse_pkg::ST_COLLECT:
            begin
                if (in_accept && keys.last_in)
                begin
                    state_next = (n_next >= CW'(2)) ? hse_pkg::ST_LOAD : hse_pkg::ST_EMIT_RD;
                end
            end
            hse_pkg::ST_LOAD:
            begin
                state_next = hse_pkg::ST_ROOT;
            end
            hse_pkg::ST_ROOT:
            begin
                state_next = left_ok ? hse_pkg::ST_SIFT : hse_pkg::ST_FINISH;
            end
            hse_pkg::ST_SWAP_RD:
            begin
                state_next = hse_pkg::ST_SWAP;
            end
            hse_pkg::ST_SWAP:
            begin
                state_next = (end_reg > AW'(1)) ? hse_pkg::ST_SIFT : hse_pkg::ST_FINISH;
            end
            hse_pkg::ST_SIFT:
            begin
                if (swap_up)
                begin
                    state_next = deeper ? hse_pkg::ST_SIFT : hse_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = after_op;
                end
            end
            hse_pkg::ST_FINISH:
            begin
                state_next = after_op;
            end
            hse_pkg::ST_EMIT_RD:
            begin
                if (emit_go)
                begin
                    state_next = hse_pkg::ST_EMIT_LD;
                end
            end
            hse_pkg::ST_EMIT_LD:
            begin
                state_next = emit_last ? hse_pkg::ST_COLLECT : hse_pkg::ST_EMIT_RD;
            end
            default:
            begin
                state_next = hse_pkg::ST_COLLECT;
            end
        endcase
    end

    // datapath, RAM control and output word
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        mode_next      = cfg_we ? cfg_wdata : mode_reg;
        size_next      = size_reg;
        cur_next       = cur_reg;
        par_next       = par_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        extract_next   = extract_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = hold_reg;
        ram_raddr_a    = '0;
        ram_raddr_b    = '0;

        if (out_valid_reg && sorted.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            hse_pkg::ST_COLLECT:
            begin
                if (in_accept)
                begin
                    if (room)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = key_k;
                        count_next = n_next;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (keys.last_in)
                    begin
                        size_next    = n_next;
                        par_next     = n_half[AW-1:0];
                        cur_next     = n_half[AW-1:0];
                        extract_next = 1'b0;
                        idx_next     = '0;
                    end
                end
            end
            hse_pkg::ST_LOAD:
            begin
                ram_raddr_a = cur_reg;
            end
            hse_pkg::ST_ROOT:
            begin
                hold_next   = rda;
                ram_raddr_a = lc_cur[AW-1:0];
                ram_raddr_b = rc_cur[AW-1:0];
            end
            hse_pkg::ST_SWAP_RD:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = end_reg;
            end
            hse_pkg::ST_SWAP:
            begin
                // old root goes to the end, old end value sifts down from the root
                ram_we      = 1'b1;
                ram_waddr   = end_reg;
                ram_wdata   = rda;
                hold_next   = rdb;
                cur_next    = '0;
                size_next   = CW'(end_reg);
                ram_raddr_a = AW'(1);
                ram_raddr_b = AW'(2);
            end
            hse_pkg::ST_SIFT:
            begin
                ram_we = 1'b1;
                if (swap_up)
                begin
                    ram_wdata   = big_val;
                    cur_next    = big_idx;
                    ram_raddr_a = lc_big[AW-1:0];
                    ram_raddr_b = rc_big[AW-1:0];
                end
            end
            hse_pkg::ST_FINISH:
            begin
                ram_we = 1'b1;
            end
            hse_pkg::ST_EMIT_RD:
            begin
                ram_raddr_a = idx_reg;
            end
            hse_pkg::ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_key_next   = rd_wide[hse_pkg::FIELD_W-1:0];
                out_last_next  = emit_last;
                out_drop_next  = ovf_reg;
                idx_next       = idx_reg + AW'(1);
                if (emit_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        if (op_done)
        begin
            if (!extract_reg)
            begin
                if (par_reg != '0)
                begin
                    par_next = par_reg - AW'(1);
                    cur_next = par_reg - AW'(1);
                end
                else
                begin
                    extract_next = 1'b1;
                    end_next     = count_m1[AW-1:0];
                end
            end
            else
            begin
                end_next = end_reg - AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hse_pkg::ST_COLLECT;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            extract_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            size_reg      <= '0;
            cur_reg       <= '0;
            par_reg       <= '0;
            end_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            mode_reg      <= mode_next;
            extract_reg   <= extract_next;
            out_valid_reg <= out_valid_next;
            size_reg      <= size_next;
            cur_reg       <= cur_next;
            par_reg       <= par_next;
            end_reg       <= end_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

endmodule

// ----- sv/hse_checker.sv -----
// ---------------------------------------------------------------------------
// hse_checker
// Port-level checks of the heap sort engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "heap_sort_engine_assert.svh"

module hse_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_last,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_last,
    input logic [hse_pkg::FIELD_W-1:0]  out_key
);

    logic final_word;

    assign final_word = out_valid && out_last;

    // a last key starts the sort, so no word is taken the cycle after
    `HSE_ASSERT_NEXT(a_sort_after_last, in_valid && in_ready && in_last, !in_ready, "key taken during sort")

    // mid-run words only appear while the input is closed
    `HSE_ASSERT_NOW(a_no_input_mid_run, out_valid && !out_last, !in_ready, "input open during emit")

    // the final word of a run reopens the input
    `HSE_ASSERT_NOW(a_reopen_on_final, final_word && !$past(final_word), in_ready, "input closed after run")

    // a stalled word holds
    `HSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key), "stalled word changed")

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (keys.valid),
    .in_ready  (keys.ready),
    .in_last   (keys.last_in),
    .out_valid (sorted.valid),
    .out_ready (sorted.ready),
    .out_last  (sorted.last_out),
    .out_key   (sorted.sorted_key)
);

// ----- dv/heap_sort_engine_tb.sv -----
// ---------------------------------------------------------------------------
// heap_sort_engine_tb
// Self-checking bench for the heap sort engine. Key sets go in on the key
// channel and the sorted words are checked in order against an in-bench sorter
// that tracks the store depth, the overflow flag and the compare mode. A short
// table of corner sets runs first, then full sets, then random sets with mode
// changes between sets; random gaps on both channels and one long output stall.
// ---------------------------------------------------------------------------
module heap_sort_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W      = hse_pkg::FIELD_W;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int DEPTH        = hse_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 64;
    localparam int SETTLE       = 8;     // cycles after the last word before a mode write
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_AT      = 25;    // word count that starts the long output stall
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 6000;  // cycles with no word moving on either channel

    typedef struct packed {
        logic [FIELD_W-1:0] sorted_key;
        logic               last_out;
        logic               dropped;
    } sorted_word_t;

    typedef struct {
        bit               mode;
        bit [FIELD_W-1:0] key;
        bit               last;
        bit               typed;     // expected word written in the row
        bit [FIELD_W-1:0] exp_key;
    } stim_row_t;

    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_CORNER,
        MIX_NEAR_ZERO
    } key_mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic cfg_wdata;

    hse_key_if    keys_if ();
    hse_sorted_if sorted_if ();

    heap_sort_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys_if),
        .sorted    (sorted_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // single-key sets carry their result in the row
    stim_row_t dir_rows [17] = '{
        '{1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{1'b0, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
        '{1'b1, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b1, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b1, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
        '{1'b1, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
        '{1'b1, 32'h5555_5555, 1'b1, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0001, 1'b1, 1'b0, 32'h0}
    };

    // sorter state
    bit [FIELD_W-1:0] collected_keys [$];
    bit               keys_lost = 1'b0;
    bit               mode_signed = 1'b0;
    sorted_word_t     sorted_words_due [$];

    int mismatches = 0;
    bit wind_down = 1'b0;

    function automatic bit [FIELD_W-1:0] order_rank(bit [FIELD_W-1:0] k);
        return mode_signed ? (k ^ 32'h8000_0000) : k;
    endfunction

    // takes one accepted key; a closing key sorts the set into words
    function automatic void collect_and_sort(bit [FIELD_W-1:0] k, bit last, bit queue_words);
        bit [FIELD_W-1:0] run [$];
        bit [FIELD_W-1:0] v;
        int               j;
        sorted_word_t     w;
        if (collected_keys.size() < DEPTH)
            collected_keys.push_back(k);
        else
            keys_lost = 1'b1;
        if (!last)
            return;
        run = collected_keys;
        for (int i = 1; i < run.size(); i++)
        begin
            v = run[i];
            j = i;
            while (j > 0 && order_rank(run[j-1]) > order_rank(v))
            begin
                run[j] = run[j-1];
                j--;
            end
            run[j] = v;
        end
        if (queue_words)
        begin
            foreach (run[i])
            begin
                w.sorted_key = run[i];
                w.last_out   = (i == run.size() - 1);
                w.dropped    = keys_lost;
                sorted_words_due.push_back(w);
            end
        end
        collected_keys.delete();
        keys_lost = 1'b0;
    endfunction

    function automatic bit [FIELD_W-1:0] make_key(key_mix_t mix);
        case (mix)
            MIX_NARROW:
                return $urandom_range(0, 7);
            MIX_CORNER:
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    default: return $urandom;
                endcase
            MIX_NEAR_ZERO:
                return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) | $urandom_range(0, 15);
            default:
                return $urandom;
        endcase
    endfunction

    task automatic report_field(string field, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] seen);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, seen);
    endtask

    task automatic pause_sender(int n);
        keys_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold the key channel until every word is out and the engine is back to collecting
    task automatic wait_idle();
        keys_if.valid <= 1'b0;
        while (sorted_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(bit m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_signed = m;
    endtask

    task automatic send_key(bit [FIELD_W-1:0] k, bit last, bit queue_words);
        keys_if.valid   <= 1'b1;
        keys_if.key     <= k;
        keys_if.last_in <= last;
        @(posedge clk);
        while (!keys_if.ready)
            @(posedge clk);
        collect_and_sort(k, last, queue_words);
    endtask

    task automatic send_set(int n, key_mix_t mix, bit gaps);
        for (int i = 0; i < n; i++)
        begin
            if (gaps && !wind_down && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 3));
            send_key(make_key(mix), i == n - 1, 1'b1);
        end
    endtask

    // key side: directed table, full-store sets, then random sets
    initial
    begin : key_source
        bit set_open;
        int random_keys;
        int pick;
        int size;
        set_open        = 1'b0;
        random_keys     = 0;
        keys_if.valid   = 1'b0;
        keys_if.key     = '0;
        keys_if.last_in = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        foreach (dir_rows[r])
        begin
            if (!set_open && dir_rows[r].mode != mode_signed)
            begin
                wait_idle();
                write_mode(dir_rows[r].mode);
            end
            send_key(dir_rows[r].key, dir_rows[r].last, !dir_rows[r].typed);
            if (dir_rows[r].typed)
                sorted_words_due.push_back('{dir_rows[r].exp_key, 1'b1, 1'b0});
            set_open = !dir_rows[r].last;
        end

        // exactly full store, then a set whose last two keys overflow
        send_set(DEPTH, MIX_FULL, 1'b1);
        send_set(DEPTH + 2, MIX_NARROW, 1'b1);
        wait_idle();
        write_mode(1'b1);

        while (random_keys < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                write_mode($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 85)
                size = $urandom_range(1, 8);
            else if (pick < 97)
                size = $urandom_range(9, 40);
            else
                size = $urandom_range(DEPTH, DEPTH + 3);
            send_set(size, key_mix_t'($urandom_range(0, 3)), $urandom_range(0, 2) != 0);
            random_keys += size;
            wind_down = (random_keys >= RANDOM_ITEMS * 4 / 5);
        end

        keys_if.valid <= 1'b0;
        while (sorted_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // sorted side: checks each word against the oldest one due
    initial
    begin : sorted_sink
        sorted_word_t seen;
        sorted_word_t want;
        int           stall_left;
        int           hold_left;
        int           window_left;
        int           words_seen;
        bit           gaps_on;
        bit           hold_done;
        stall_left      = 0;
        hold_left       = 0;
        window_left     = 0;
        words_seen      = 0;
        gaps_on         = 1'b0;
        hold_done       = 1'b0;
        sorted_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sorted_if.valid && sorted_if.ready)
            begin
                seen = '{sorted_if.sorted_key, sorted_if.last_out, sorted_if.dropped};
                words_seen++;
                if (sorted_words_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected word, expected none, actual %h/%b/%b",
                             $time, seen.sorted_key, seen.last_out, seen.dropped);
                end
                else
                begin
                    want = sorted_words_due.pop_front();
                    if (seen.sorted_key !== want.sorted_key)
                        report_field("sorted_key", want.sorted_key, seen.sorted_key);
                    if (seen.last_out !== want.last_out)
                        report_field("last_out", want.last_out, seen.last_out);
                    if (seen.dropped !== want.dropped)
                        report_field("dropped", want.dropped, seen.dropped);
                end
                if (!hold_done && words_seen == HOLD_AT)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            // gaps come and go in windows so some stretches run clean
            if (window_left == 0)
            begin
                window_left = 32;
                gaps_on     = $urandom_range(0, 2) != 0;
            end
            window_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                sorted_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                sorted_if.ready <= 1'b0;
            end
            else if (gaps_on && !wind_down && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                sorted_if.ready <= 1'b0;
            end
            else
                sorted_if.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((keys_if.valid && keys_if.ready) || (sorted_if.valid && sorted_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- heap_sort_engine.f -----
+incdir+sv
sv/hse_pkg.sv
sv/hse_if.sv
sv/hse_ram.sv
sv/heap_sort_engine.sv
sv/hse_checker.sv
dv/heap_sort_engine_tb.sv
